// ===== src/db_taper_volume_gain_defines.svh =====
// Assertion macros shared by the volume gain block.
// No dependencies.
`ifndef DB_TAPER_VOLUME_GAIN_DEFINES_SVH
`define DB_TAPER_VOLUME_GAIN_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define DTV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DTV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/dtv_pkg.sv =====
// Package for the decibel-taper volume gain block: constants and exp2 table.
// No dependencies.
`default_nettype none
package dtv_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_RAW_VOLUME  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RAW_MINIMUM = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RAW_MAXIMUM = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DB_MINIMUM  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DB_MAXIMUM  = 3'd4;
  localparam logic [21:0] LOG2_TEN_OVER_TWENTY_Q24 = 22'd2786635;

  function automatic logic [17:0] exp2_entry(input logic [4:0] idx);
    logic [17:0] v;
    case (idx)
      5'd0: v = 18'd65536;   5'd1: v = 18'd68438;   5'd2: v = 18'd71468;
      5'd3: v = 18'd74632;   5'd4: v = 18'd77936;   5'd5: v = 18'd81386;
      5'd6: v = 18'd84990;   5'd7: v = 18'd88752;   5'd8: v = 18'd92682;
      5'd9: v = 18'd96785;   5'd10: v = 18'd101070; 5'd11: v = 18'd105545;
      5'd12: v = 18'd110218; 5'd13: v = 18'd115098; 5'd14: v = 18'd120194;
      5'd15: v = 18'd125515; 5'd16: v = 18'd131072;
      default: v = 18'd65536;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== src/dtv_stream_if.sv =====
// Valid/ready stream interface carrying one sample and its buffer-end marker.
// No dependencies.
`default_nettype none
interface dtv_stream_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic                           buffer_end;
  modport source (output valid, output sample, output buffer_end, input ready);
  modport sink   (input valid, input sample, input buffer_end, output ready);
endinterface
`default_nettype wire

// ===== src/db_taper_volume_gain.sv =====
// Top level of the decibel-taper volume gain block.
// Depends on dtv_pkg, dtv_stream_if, dtv_gain_calc, dtv_front, dtv_back.
//
//   Channel  | Direction | Carries
//   in_ch    | sink      | sample, buffer_end marker
//   out_ch   | source    | gained sample, buffer_end marker
//   cfg_*    | write     | five 16-bit volume registers
//
// One sample enters per cycle unless input is held off or the queue is full; the
// accepting edge loads the queue, then the sample passes the multiplier register
// and the output register.
// After a configuration write the gain unit runs up to a 16-step divider plus
// four stages; input is held off until the new gain is in place.
// Reset is synchronous; the gain resets to unity. Output stalls fill the
// two-entry queue before input ready falls.
`default_nettype none
module db_taper_volume_gain
  import dtv_pkg::*;
#(
  parameter int SAMPLE_WIDTH       = 24,
  parameter int GAIN_FRACTION_BITS = 20
) (
  input  wire                clk,
  input  wire                rst_n,
  dtv_stream_if.sink         in_ch,
  dtv_stream_if.source       out_ch,
  input  wire                cfg_we,
  input  wire [CfgIdxW-1:0]  cfg_index,
  input  wire [15:0]         cfg_data
);
  logic        [15:0] raw_volume_r, raw_minimum_r, raw_maximum_r;
  logic signed [15:0] db_minimum_r, db_maximum_r;
  logic               pend_r;
  logic               calc_busy, back_busy;
  logic               q_valid, q_pop, q_end;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;
  logic [GAIN_FRACTION_BITS+3:0]  gain;
  logic               start;

  // The gain is recomputed once the pipeline has drained after a write.
  assign start = pend_r && !calc_busy && !q_valid && !back_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_volume_r  <= 16'd65535;
      raw_minimum_r <= 16'd0;
      raw_maximum_r <= 16'd65535;
      db_minimum_r  <= -16'sd24576;
      db_maximum_r  <= 16'sd0;
      pend_r        <= 1'b0;
    end else begin
      if (start) pend_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_RAW_VOLUME:  begin raw_volume_r  <= cfg_data; pend_r <= 1'b1; end
          REG_RAW_MINIMUM: begin raw_minimum_r <= cfg_data; pend_r <= 1'b1; end
          REG_RAW_MAXIMUM: begin raw_maximum_r <= cfg_data; pend_r <= 1'b1; end
          REG_DB_MINIMUM:  begin db_minimum_r  <= cfg_data; pend_r <= 1'b1; end
          REG_DB_MAXIMUM:  begin db_maximum_r  <= cfg_data; pend_r <= 1'b1; end
          default: ;
        endcase
      end
    end
  end

  dtv_gain_calc #(.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_calc (
    .clk(clk), .rst_n(rst_n), .start(start),
    .raw_volume(raw_volume_r), .raw_minimum(raw_minimum_r),
    .raw_maximum(raw_maximum_r), .db_minimum(db_minimum_r),
    .db_maximum(db_maximum_r), .busy(calc_busy), .gain(gain)
  );

  dtv_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .hold(pend_r || calc_busy || cfg_we),
    .in_ch(in_ch), .q_valid(q_valid), .q_pop(q_pop),
    .q_sample(q_sample), .q_end(q_end)
  );

  dtv_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop),
    .q_sample(q_sample), .q_end(q_end), .gain(gain), .busy(back_busy),
    .out_ch(out_ch)
  );

  `include "db_taper_volume_gain_defines.svh"
  `DTV_ASSERT_IMPL(a_hold_calc, clk, rst_n, calc_busy, !in_ch.ready)
  `DTV_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !cfg_we, calc_busy || !pend_r)
endmodule
`default_nettype wire

// ===== src/dtv_gain_calc.sv =====
// Gain computation: raw step to Q0.16 fraction (serial divider), dB level,
// log2 and exp2 table lookup, multi-cycle. Depends on dtv_pkg.
`default_nettype none
module dtv_gain_calc
  import dtv_pkg::*;
#(
  parameter int GAIN_FRACTION_BITS = 20
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire        [15:0]                 raw_volume,
  input  wire        [15:0]                 raw_minimum,
  input  wire        [15:0]                 raw_maximum,
  input  wire signed [15:0]                 db_minimum,
  input  wire signed [15:0]                 db_maximum,
  output logic                              busy,
  output logic       [GAIN_FRACTION_BITS+3:0] gain
);
  localparam int GW = GAIN_FRACTION_BITS + 4;
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_DB, S_LOG, S_EXP, S_SCALE} state_t;

  state_t              state_r;
  logic [4:0]          cnt_r;
  logic [16:0]         rem_r;
  logic [16:0]         den_r;
  logic [16:0]         quo_r;
  logic signed [17:0]  dbm_r;
  logic signed [17:0]  span_r;
  logic signed [16:0]  db_r;
  logic signed [39:0]  lg_r;
  logic [17:0]         mant_r;
  logic [GW-1:0]       gain_r;

  logic signed [17:0]  rng;
  logic signed [17:0]  num;
  logic [17:0]         rem_sh;
  logic signed [35:0]  prod_db;
  logic signed [39:0]  prod_lg;
  logic signed [23:0]  ex;
  logic [15:0]         fr;
  logic [17:0]         t0;
  logic [17:0]         t1;
  logic [29:0]         dlt;
  logic signed [24:0]  sh;
  logic [GW+17:0]      wide;
  logic [GW-1:0]       cap;

  assign rng     = $signed({2'b00, raw_maximum}) - $signed({2'b00, raw_minimum});
  assign num     = $signed({2'b00, raw_volume}) - $signed({2'b00, raw_minimum});
  assign rem_sh  = {rem_r, 1'b0};
  assign prod_db = $signed({1'b0, quo_r}) * span_r;
  assign prod_lg = db_r * $signed({1'b0, LOG2_TEN_OVER_TWENTY_Q24});
  assign ex      = lg_r[39:16];
  assign fr      = lg_r[15:0];
  assign t0      = exp2_entry({1'b0, fr[15:12]});
  assign t1      = exp2_entry({1'b0, fr[15:12]} + 5'd1);
  assign dlt     = (t1 - t0) * fr[11:0];
  assign sh      = $signed({ex[23], ex}) + 25'(GAIN_FRACTION_BITS - 16);
  assign cap     = {GW{1'b1}};

  // The mantissa is at least 2^16, so any left shift of GW-16 or more is
  // already past the cap; smaller shifts always fit in the wide result.
  always_comb begin
    wide = '0;
    if (sh >= 0) begin
      if (sh >= 25'(GW - 16)) wide = {18'd0, cap};
      else wide = (GW+18)'(mant_r) << sh[5:0];
    end else if (sh >= -25'sd62) begin
      wide = (GW+18)'(mant_r) >> 6'(-sh);
    end
  end

  assign busy = (state_r != S_IDLE);
  assign gain = gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      gain_r  <= GW'(1) << GAIN_FRACTION_BITS;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            dbm_r  <= 18'(db_minimum);
            span_r <= 18'(db_maximum) - 18'(db_minimum);
            if (rng <= 0 || num >= rng) begin
              gain_r <= GW'(1) << GAIN_FRACTION_BITS;
            end else if (num <= 0) begin
              gain_r <= '0;
            end else begin
              // Restoring division of num*2^16 by rng, one quotient bit per cycle.
              rem_r   <= 17'(num);
              den_r   <= 17'(rng);
              quo_r   <= '0;
              cnt_r   <= 5'd16;
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, den_r}) begin
            rem_r <= 17'(rem_sh - {1'b0, den_r});
            quo_r <= {quo_r[15:0], 1'b1};
          end else begin
            rem_r <= rem_sh[16:0];
            quo_r <= {quo_r[15:0], 1'b0};
          end
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd1) state_r <= S_DB;
        end
        S_DB: begin
          if (quo_r == '0) begin
            gain_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            db_r    <= 17'(dbm_r + 18'(prod_db >>> 16));
            state_r <= S_LOG;
          end
        end
        S_LOG: begin
          lg_r    <= prod_lg >>> 16;
          state_r <= S_EXP;
        end
        S_EXP: begin
          mant_r  <= t0 + 18'(dlt >> 12);
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          gain_r  <= (wide > (GW+18)'(cap)) ? cap : wide[GW-1:0];
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "db_taper_volume_gain_defines.svh"
  `DTV_ASSERT_NEXT(a_div_len, clk, rst_n, state_r == S_DIV && cnt_r == 5'd1, state_r == S_DB)
  `DTV_ASSERT_IMPL(a_div_cnt, clk, rst_n, state_r == S_DIV, cnt_r != 5'd0)
  `DTV_ASSERT_IMPL(a_gain_cap, clk, rst_n, 1'b1, gain_r <= cap)
endmodule
`default_nettype wire

// ===== src/dtv_front.sv =====
// Front end: accepts samples into a two-entry queue so the back end can stall.
// Depends on dtv_stream_if.
`default_nettype none
module dtv_front #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           hold,
  dtv_stream_if.sink                    in_ch,
  output logic                          q_valid,
  input  wire                           q_pop,
  output logic signed [SAMPLE_WIDTH-1:0] q_sample,
  output logic                          q_end
);
  logic signed [SAMPLE_WIDTH-1:0] smp_r [2];
  logic [1:0]                     end_r;
  logic                           wp_r, rp_r;
  logic [1:0]                     cnt_r;
  logic                           push, pop;

  assign in_ch.ready = !hold && (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_pop && q_valid;
  assign q_sample    = smp_r[rp_r];
  assign q_end       = end_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      smp_r[wp_r] <= in_ch.sample;
      end_r[wp_r] <= in_ch.buffer_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  `include "db_taper_volume_gain_defines.svh"
  `DTV_ASSERT_IMPL(a_no_overflow, clk, rst_n, cnt_r == 2'd2, !push || pop)
  `DTV_ASSERT_IMPL(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3)
endmodule
`default_nettype wire

// ===== src/dtv_back.sv =====
// Back end: multiplies a sample by the gain, rounds, saturates; output register.
// Depends on dtv_stream_if.
`default_nettype none
module dtv_back #(
  parameter int SAMPLE_WIDTH       = 24,
  parameter int GAIN_FRACTION_BITS = 20
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              q_valid,
  output logic                             q_pop,
  input  wire signed [SAMPLE_WIDTH-1:0]    q_sample,
  input  wire                              q_end,
  input  wire        [GAIN_FRACTION_BITS+3:0] gain,
  output logic                             busy,
  dtv_stream_if.source                     out_ch
);
  localparam int GW = GAIN_FRACTION_BITS + 4;
  localparam int PW = SAMPLE_WIDTH + GW + 1;
  localparam int YW = PW - GAIN_FRACTION_BITS;

  logic                           m_valid_r;
  logic signed [PW-1:0]           prod_r;
  logic                           m_end_r;
  logic                           o_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] o_smp_r;
  logic                           o_end_r;
  logic                           o_free, m_go;
  logic signed [PW-1:0]           rnd;
  logic signed [YW-1:0]           y;
  logic signed [YW-1:0]           hi, lo;
  logic signed [SAMPLE_WIDTH-1:0] sat;

  assign o_free  = !o_valid_r || out_ch.ready;
  assign m_go    = !m_valid_r || o_free;
  assign q_pop   = m_go;
  assign rnd     = prod_r + (PW'(1) <<< (GAIN_FRACTION_BITS - 1));
  assign y       = YW'(rnd >>> GAIN_FRACTION_BITS);
  assign hi      = YW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
  assign lo      = -hi - YW'(1);
  assign sat     = (y > hi) ? hi[SAMPLE_WIDTH-1:0] :
                   (y < lo) ? lo[SAMPLE_WIDTH-1:0] : y[SAMPLE_WIDTH-1:0];
  assign busy    = m_valid_r || o_valid_r;

  assign out_ch.valid      = o_valid_r;
  assign out_ch.sample     = o_smp_r;
  assign out_ch.buffer_end = o_end_r;

  always_ff @(posedge clk) begin
    if (m_go) begin
      prod_r  <= PW'(q_sample) * $signed({1'b0, gain});
      m_end_r <= q_end;
    end
    if (o_free) begin
      o_smp_r <= sat;
      o_end_r <= m_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0; o_valid_r <= 1'b0;
    end else begin
      if (m_go) m_valid_r <= q_valid;
      if (o_free) o_valid_r <= m_valid_r;
    end
  end

  `include "db_taper_volume_gain_defines.svh"
  `DTV_ASSERT_NEXT(a_out_hold, clk, rst_n, o_valid_r && !out_ch.ready, o_valid_r)
  `DTV_ASSERT_IMPL(a_pop_free, clk, rst_n, q_pop && m_valid_r, o_free)
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the decibel-taper volume gain block.
// Depends on dtv_pkg, dtv_stream_if and db_taper_volume_gain from the RTL.
`default_nettype none
module testbench;
  import dtv_pkg::*;

  localparam int SW = 24;
  localparam int GFB = 20;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 buffer_end;
  } request_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [15:0] cfg_data;

  dtv_stream_if #(.SAMPLE_WIDTH(SW)) in_ch ();
  dtv_stream_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  db_taper_volume_gain #(.SAMPLE_WIDTH(SW), .GAIN_FRACTION_BITS(GFB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the five volume registers, updated once all five are written.
  logic [15:0] vol_raw, vol_min, vol_max, level_min, level_max;

  // Powers of two 2^(i/16) in Q16, used to build the linear gain mantissa.
  longint exp2_q16 [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
                            92682, 96785, 101070, 105545, 110218, 115098, 120194,
                            125515, 131072};

  request_t pending_samples[$];
  request_t gained_q[$];
  int in_idle_pct, out_idle_pct;
  int out_hold;
  int mismatches;
  int cycles;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Converts a level in 1/256 dB to a Q4.20 linear gain, saturated.
  function automatic longint level_to_gain(longint level);
    longint l2, e, f, idx, t, m, s, g;
    longint cap;
    cap = (longint'(1) << (4 + GFB)) - 1;
    l2 = (level * 2786635) >>> 16;
    e = l2 >>> 16;
    f = l2 & 64'hFFFF;
    idx = f >> 12;
    t = f & 64'hFFF;
    m = exp2_q16[idx] + (((exp2_q16[idx+1] - exp2_q16[idx]) * t) >> 12);
    s = e + GFB - 16;
    if (s >= 0) begin
      if (s > 40) return cap;
      g = m << s;
    end else begin
      if (s < -62) return 0;
      g = m >> (-s);
    end
    return (g > cap) ? cap : g;
  endfunction

  // Gain that the current register settings call for.
  function automatic longint volume_gain();
    longint span, num, frac, level;
    span = longint'(vol_max) - longint'(vol_min);
    num = longint'(vol_raw) - longint'(vol_min);
    // An empty or inverted range, or a step at the top, is exactly unity.
    if (span <= 0 || num >= span) return longint'(1) << GFB;
    if (num <= 0) return 0;
    frac = (num << 16) / span;
    if (frac <= 0) return 0;
    level = longint'($signed(level_min))
          + ((frac * (longint'($signed(level_max)) - longint'($signed(level_min)))) >>> 16);
    return level_to_gain(level);
  endfunction

  // Applies the gain with round-half-up and saturates to full scale.
  function automatic request_t gain_sample(request_t req);
    request_t res;
    longint y;
    y = (longint'(req.sample) * volume_gain() + (longint'(1) << (GFB - 1))) >>> GFB;
    if (y > 8388607) y = 8388607;
    if (y < -8388608) y = -8388608;
    res.sample = y[SW-1:0];
    res.buffer_end = req.buffer_end;
    return res;
  endfunction

  // Sender: holds a request until it is taken, otherwise offers the next one
  // unless it decides to idle this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
      in_ch.buffer_end <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid && in_ch.ready) void'(pending_samples.pop_front());
      if (pending_samples.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.sample <= pending_samples[0].sample;
        in_ch.buffer_end <= pending_samples[0].buffer_end;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: a long hold-off when requested, random stalls otherwise.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Monitor: predicts each accepted request and checks each delivered result
  // against the oldest prediction.
  always @(posedge clk) begin
    request_t got, want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        got.sample = in_ch.sample;
        got.buffer_end = in_ch.buffer_end;
        gained_q.push_back(gain_sample(got));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.sample = out_ch.sample;
        got.buffer_end = out_ch.buffer_end;
        if (gained_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: sample %0d end %0b", got.sample, got.buffer_end);
        end else begin
          want = gained_q.pop_front();
          if (got.sample !== want.sample || got.buffer_end !== want.buffer_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result differs: expected sample %0d end %0b, got sample %0d end %0b",
                       want.sample, want.buffer_end, got.sample, got.buffer_end);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("db_taper_volume_gain: mismatch");
      $finish;
    end
  end

  // Waits until every request went through and every result came back, plus
  // enough cycles for the pipeline to settle.
  task automatic wait_drained();
    while (pending_samples.size() > 0 || gained_q.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Writes all five registers back to back; the block is idle here.
  task automatic write_volume(logic [15:0] raw, logic [15:0] lo, logic [15:0] hi,
                              logic [15:0] dbl, logic [15:0] dbh);
    logic [CfgIdxW-1:0] idx [5];
    logic [15:0] val [5];
    idx = '{REG_RAW_VOLUME, REG_RAW_MINIMUM, REG_RAW_MAXIMUM, REG_DB_MINIMUM, REG_DB_MAXIMUM};
    val = '{raw, lo, hi, dbl, dbh};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    vol_raw = raw;
    vol_min = lo;
    vol_max = hi;
    level_min = dbl;
    level_max = dbh;
  endtask

  function automatic request_t make_request(logic signed [SW-1:0] s, logic e);
    request_t r;
    r.sample = s;
    r.buffer_end = e;
    return r;
  endfunction

  function automatic logic [15:0] random_level();
    return 16'(int'($urandom_range(38912)) - 32768);
  endfunction

  initial begin
    logic [15:0] lo, hi, raw;
    int n;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.buffer_end = 1'b0;
    out_ch.ready = 1'b0;
    in_idle_pct = 30;
    out_idle_pct = 30;
    out_hold = 0;
    mismatches = 0;
    cycles = 0;
    vol_raw = 16'hFFFF;
    vol_min = 16'h0000;
    vol_max = 16'hFFFF;
    level_min = 16'hA000;
    level_max = 16'h0000;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings give unity gain, so the extremes pass as is.
    pending_samples.push_back(make_request(24'sh7FFFFF, 1'b0));
    pending_samples.push_back(make_request(24'sh800000, 1'b1));
    pending_samples.push_back(make_request(24'sh000000, 1'b0));
    pending_samples.push_back(make_request(-24'sd1, 1'b1));
    pending_samples.push_back(make_request(24'sd1, 1'b0));
    pending_samples.push_back(make_request(24'sh555555, 1'b1));
    pending_samples.push_back(make_request(24'shAAAAAA, 1'b0));

    for (int phase = 0; phase < 16; phase++) begin
      wait_drained();
      case (phase)
        // Loudest level, just under +24 dB: samples clip both ways.
        0: write_volume(16'd65534, 16'd0, 16'd65535, 16'h8000, 16'd6144);
        // Step at the bottom of the range: gain is exactly zero.
        1: write_volume(16'd100, 16'd100, 16'd5000, 16'hA000, 16'd0);
        // Step above the top: exactly unity.
        2: write_volume(16'd65535, 16'd0, 16'd40000, 16'h8000, 16'h8000);
        // Inverted raw range: unity.
        3: write_volume(16'd300, 16'd65535, 16'd0, 16'h8000, 16'd6144);
        // Quietest level: gain floors toward zero.
        4: write_volume(16'd1, 16'd0, 16'd65535, 16'h8000, 16'h8000);
        // Inverted decibel limits, with a range of two steps.
        5: write_volume(16'd1, 16'd0, 16'd2, 16'd6144, 16'h8000);
        // Step just below the top with a +24 dB ceiling.
        6: write_volume(16'd65534, 16'd0, 16'd65535, 16'h0000, 16'd6144);
        default: begin
          lo = 16'($urandom);
          hi = 16'($urandom);
          if ($urandom_range(3) != 0 && hi < lo) {lo, hi} = {hi, lo};
          raw = (hi > lo) ? 16'($urandom_range(hi, lo)) : 16'($urandom);
          write_volume(raw, lo, hi, random_level(), random_level());
        end
      endcase

      // Idling mix: a phase with none, the rest about thirty percent.
      in_idle_pct = (phase == 8) ? 0 : 30;
      out_idle_pct = (phase == 8) ? 0 : 30;
      // One phase holds the receiver off while the sender keeps offering.
      if (phase == 10) out_hold <= 300;

      pending_samples.push_back(make_request(24'sh7FFFFF, 1'b1));
      pending_samples.push_back(make_request(24'sh800000, 1'b0));
      n = 105;
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(7))
          0: pending_samples.push_back(make_request(24'($urandom_range(15)) - 24'sd8,
                                                   1'($urandom)));
          default: pending_samples.push_back(make_request(24'($urandom), 1'($urandom)));
        endcase
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("db_taper_volume_gain: match");
    end else begin
      $display("db_taper_volume_gain: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
